FILE: design/frustum_cull_test_unit_defines.svh
// Assertion macros shared by the frustum cull checker
`ifndef FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define FCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("frustum cull check failed");

// next-cycle implication, off while in reset
`define FCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("frustum cull check failed");

// checked on every edge, reset included
`define FCT_ASSERT_ALWAYS(lbl, clk, cond) \
	lbl: assert property (@(posedge clk) (cond)) \
		else $error("frustum cull check failed");

`endif

FILE: design/fct_pkg.sv
// Types, constants and command codes for the frustum cull unit
package fct_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int MAX_PLANES     = 6;

	localparam int CMD_W    = 2;
	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int NORM_W   = 12;
	localparam int OFFS_W   = 28;
	localparam int PLANE_W  = 64;
	localparam int CFG_IDX_W = 3;

	// plane register layout
	localparam int NORM_LSB = 0;
	localparam int OFFS_LSB = 36;
	localparam int FRAC_ALIGN = 10;

	localparam int PROD_W = NORM_W + COORD_W;   // 36
	localparam int PSUM_W = PROD_W + 2;         // 38
	localparam int ACC_W  = PSUM_W + 2;         // 40

	typedef enum logic [CMD_W-1:0] {
		CMD_POINT  = 2'd0,
		CMD_SPHERE = 2'd1,
		CMD_BOX    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_e;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [RADIUS_W-1:0]       radius_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic signed [OFFS_W-1:0]  offs_t;
	typedef logic [PLANE_W-1:0]        plane_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [PSUM_W-1:0]  psum_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	// load enables of the three arithmetic stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

FILE: design/fct_ifs.sv
// Handshake channel interfaces: object in, result out, configuration write
interface fct_obj_if;
	logic                              valid;
	logic                              ready;
	logic [fct_pkg::CMD_W-1:0]         command;
	logic signed [fct_pkg::COORD_W-1:0] low_x;
	logic signed [fct_pkg::COORD_W-1:0] low_y;
	logic signed [fct_pkg::COORD_W-1:0] low_z;
	logic signed [fct_pkg::COORD_W-1:0] high_x;
	logic signed [fct_pkg::COORD_W-1:0] high_y;
	logic signed [fct_pkg::COORD_W-1:0] high_z;
	logic [fct_pkg::RADIUS_W-1:0]      radius;

	modport source (output valid, command, low_x, low_y, low_z, high_x, high_y, high_z,
		radius, input ready);
	modport sink (input valid, command, low_x, low_y, low_z, high_x, high_y, high_z,
		radius, output ready);
endinterface

interface fct_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

interface fct_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fct_pkg::CFG_IDX_W-1:0]   index;
	logic [fct_pkg::PLANE_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/fct_plane_regs.sv
// Plane register bank, written through the configuration channel
module fct_plane_regs #(
	parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fct_pkg::CFG_IDX_W-1:0] wr_index,
	input  fct_pkg::plane_t               wr_data,
	output fct_pkg::plane_t [NUM_PLANES-1:0] planes
);
	import fct_pkg::*;

	plane_t [NUM_PLANES-1:0] plane_q;

	// indexes past the last plane fall through untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (wr_index == CFG_IDX_W'(i)) begin
					plane_q[i] <= wr_data;
				end
			end
		end
	end

	assign planes = plane_q;

endmodule

FILE: design/fct_plane_lane.sv
// One plane's datapath: corner pick and products, dot sum, offset compare
module fct_plane_lane (
	input  logic                       clk,
	input  fct_pkg::stage_en_t         en,
	input  fct_pkg::plane_t            plane,
	input  fct_pkg::cmd_e              cmd,
	input  fct_pkg::coord_t [2:0]      lo,
	input  fct_pkg::coord_t [2:0]      hi,
	input  fct_pkg::cmd_e              cmd_s2,
	input  fct_pkg::radius_t           radius_s2,
	output logic                       reject_s3
);
	import fct_pkg::*;

	norm_t  n      [3];
	coord_t v      [3];
	prod_t  prod_s1 [3];
	psum_t  psum_s2;
	offs_t  d;
	acc_t   d_acc;
	acc_t   thr;
	acc_t   acc;

	// box: take the corner least aligned with the normal
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			n[a] = $signed(plane[NORM_LSB + NORM_W*a +: NORM_W]);
			if (cmd == CMD_BOX && n[a][NORM_W-1]) begin
				v[a] = $signed(hi[a]);
			end else begin
				v[a] = $signed(lo[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= n[a] * v[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			psum_s2 <= PSUM_W'(prod_s1[0]) + PSUM_W'(prod_s1[1]) + PSUM_W'(prod_s1[2]);
		end
	end

	// offset and radius brought to 18 fraction bits
	assign d     = $signed(plane[OFFS_LSB +: OFFS_W]);
	assign d_acc = ACC_W'($signed({d, {FRAC_ALIGN{1'b0}}}));
	assign thr   = (cmd_s2 == CMD_SPHERE) ?
		$signed({{(ACC_W-RADIUS_W-FRAC_ALIGN){1'b0}}, radius_s2, {FRAC_ALIGN{1'b0}}}) :
		'0;
	assign acc   = ACC_W'(psum_s2) + d_acc - thr;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			reject_s3 <= !acc[ACC_W-1] && (acc != '0);
		end
	end

endmodule

FILE: design/frustum_cull_test_unit.sv
// Frustum cull test unit: point, sphere and box against the configured planes
//
//   channel  dir  words                                    handshake
//   obj      in   command, low_x/y/z, high_x/y/z, radius   valid/ready
//   res      out  inside_res                               valid/ready
//   cfg      in   index, data (64-bit plane word)          valid/ready, always ready
//
// One object word per cycle while the result side keeps taking. An accepted word passes
// through the products, dot sum and plane compare registers, then the output register.
// Each stage holds when the stage after it is full and stalled, so bubbles close up.
// Reset clears stage valid bits and the plane registers to zero.
module frustum_cull_test_unit #(
	parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	fct_obj_if.sink  obj,
	fct_res_if.source res,
	fct_cfg_if.sink  cfg
);
	import fct_pkg::*;

	stage_en_t en;
	logic      en4;

	logic v_s1, v_s2, v_s3, v_s4;
	cmd_e    cmd_s1, cmd_s2, cmd_s3;
	radius_t rad_s1, rad_s2;
	logic    inside_s4;

	plane_t [NUM_PLANES-1:0] planes;
	logic   [NUM_PLANES-1:0] reject_s3;
	coord_t [2:0] lo;
	coord_t [2:0] hi;
	cmd_e   cmd_in;

	assign cfg.ready = 1'b1;

	fct_plane_regs #(
		.NUM_PLANES(NUM_PLANES)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.planes   (planes)
	);

	assign en4   = !v_s4 || res.ready;
	assign en.s3 = !v_s3 || en4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;
	assign obj.ready = en.s1;

	assign cmd_in = cmd_e'(obj.command);
	assign lo = {obj.low_z, obj.low_y, obj.low_x};
	assign hi = {obj.high_z, obj.high_y, obj.high_x};

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
		fct_plane_lane u_lane (
			.clk       (clk),
			.en        (en),
			.plane     (planes[p]),
			.cmd       (cmd_in),
			.lo        (lo),
			.hi        (hi),
			.cmd_s2    (cmd_s2),
			.radius_s2 (rad_s2),
			.reject_s3 (reject_s3[p])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= obj.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en4)   v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			cmd_s1 <= cmd_in;
			rad_s1 <= obj.radius;
		end
		if (en.s2) begin
			cmd_s2 <= cmd_s1;
			rad_s2 <= rad_s1;
		end
		if (en.s3) begin
			cmd_s3 <= cmd_s2;
		end
		// unused command code tests nothing
		if (en4) begin
			inside_s4 <= (cmd_s3 == CMD_NONE) || !(|reject_s3);
		end
	end

	assign res.valid      = v_s4;
	assign res.inside_res = inside_s4;

endmodule

FILE: design/fct_checker.sv
// Port-level checks on the frustum cull unit, bound to the top level
`include "frustum_cull_test_unit_defines.svh"

module fct_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      obj_valid,
	input logic                      obj_ready,
	input logic [fct_pkg::CMD_W-1:0] obj_command,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic                      inside_res
);
	import fct_pkg::*;

	logic none_acc;

	assign none_acc = obj_valid && obj_ready && obj_command == CMD_NONE;

	`FCT_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	`FCT_ASSERT_NXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(inside_res))

	// an untested word comes out marked inside when the sink keeps taking
	`FCT_ASSERT_NXT(a_none_passes, clk, arst_n, none_acc ##1 res_ready[*3], res_valid && inside_res)

	`FCT_ASSERT_ALWAYS(a_reset_quiet, clk, arst_n || !res_valid)

endmodule

bind frustum_cull_test_unit fct_checker u_fct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.obj_valid   (obj.valid),
	.obj_ready   (obj.ready),
	.obj_command (obj.command),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.inside_res  (res.inside_res)
);
